### rtl/pixel_export_converter_macros.svh
// Assertion macros shared by the converter RTL.
// Both macros expect a clock named clk and an active-high reset named rst in scope.
`ifndef PIXEL_EXPORT_CONVERTER_MACROS_SVH
`define PIXEL_EXPORT_CONVERTER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define PEC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define PEC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/pec_pkg.sv
`default_nettype none

package pec_pkg;

  // Default for the largest image side.
  localparam int unsigned MAX_DIMENSION_DEF = 4096;
  // Compare width that covers every legal MAX_DIMENSION value.
  localparam int DIM_CMP_W = 15;

  localparam int COORD_W   = 12;
  localparam int CHAN_W    = 8;
  localparam int DIM_W     = 13;
  localparam int OFFSET_W  = 26;
  localparam int PIXEL_W   = 24;
  localparam int COUNT_W   = 2;
  localparam int S_DATA_W  = 56;
  localparam int M_DATA_W  = 56;
  localparam int CFG_ADDR_W = 3;

  localparam int NUM_STAGES = 7;

  // Reciprocal of 255 scaled by 2^23, rounded up: exact floor for numerators below 2^16.
  localparam logic [15:0] RECIP_255 = 16'd32897;
  localparam int RECIP_SHIFT = 23;

  localparam logic [COUNT_W-1:0] BPP_RGB888   = 2'd3;
  localparam logic [COUNT_W-1:0] BPP_RGBA5551 = 2'd2;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_OUTPUT_FORMAT        = 3'd0,
    REG_FLIP_VERTICAL        = 3'd1,
    REG_PREMULTIPLY_OUT      = 3'd2,
    REG_SOURCE_PREMULTIPLIED = 3'd3,
    REG_IMAGE_WIDTH          = 3'd4,
    REG_IMAGE_HEIGHT         = 3'd5
  } cfg_reg_t;

  // Everything one pixel carries down the pipeline; each stage fills in its part.
  typedef struct packed {
    logic [COORD_W-1:0]          col;
    logic [COORD_W-1:0]          row;
    logic [2:0][CHAN_W-1:0]      chan;      // red, green, blue
    logic [CHAN_W-1:0]           alpha;
    logic                        fmt_rgba;
    logic                        do_premul;
    logic                        do_unpremul;
    logic [DIM_W-1:0]            ty;
    logic [14:0]                 pitch;
    logic [13:0]                 colb;
    logic [27:0]                 off_prod;
    logic [OFFSET_W-1:0]         offset;
    logic [2:0][15:0]            num;
    logic [2:0][31:0]            pm_prod;
    logic [2:0][CHAN_W-1:0]      pm_q;
    logic [2:0][CHAN_W-1:0]      rem;
    logic [2:0][CHAN_W-1:0]      quo;
    logic [2:0]                  ovf;
    logic [2:0][CHAN_W-1:0]      val;
    logic [2:0][28:0]            q_prod;
    logic [PIXEL_W-1:0]          pixel;
    logic [COUNT_W-1:0]          bpp;
  } pipe_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [8:0] div_step(logic [7:0] rem, logic nbit, logic [7:0] den);
    logic [8:0] trial;
    trial = {rem, nbit};
    if (trial >= {1'b0, den}) begin
      div_step = {1'b1, 8'(trial - {1'b0, den})};
    end else begin
      div_step = {1'b0, trial[7:0]};
    end
  endfunction

endpackage

`default_nettype wire

### rtl/pixel_export_converter.sv
`default_nettype none
// Pixel export converter.
// Slave stream: one word per pixel (column, row, red, green, blue, alpha).
// Master stream: one word per pixel (byte offset in the export buffer, packed
// pixel bytes, valid byte count). Every input word gives exactly one output word.
// Configuration is written through cfg_wr_en/cfg_addr/cfg_wdata; the user must
// write only while no pixel is in flight, and the block does not enforce it; each write
// lands at the clock edge where cfg_wr_en is high. Throughput is one pixel per
// clock while m_tready is high. The datapath is seven register stages, 0 to 6,
// passed in order. The unpremultiply divider (two or three restoring steps per
// stage) and the offset and quantizer multipliers set the stage count.
// Every stage has its own valid bit and is refilled as soon as it empties, so
// the slave side keeps accepting while a finished word waits in the output
// stage. When the receiver stalls, the stages fill up and s_tready drops only
// once all seven hold a pixel; nothing is lost or repeated.
// Reset empties the pipeline and restores the register defaults: RGBA5551
// output, no flip, straight alpha on both sides, width and height of one.
module pixel_export_converter #(
  parameter int unsigned MAX_DIMENSION = pec_pkg::MAX_DIMENSION_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Slave stream.
  input  logic                            s_tvalid,
  output logic                            s_tready,
  // column[11:0], row[23:12], red[31:24], green[39:32], blue[47:40], alpha[55:48]
  input  logic [pec_pkg::S_DATA_W-1:0]    s_tdata,
  // Master stream.
  output logic                            m_tvalid,
  input  logic                            m_tready,
  // byte_offset[25:0], pixel_bytes[49:26], byte_count[51:50], zero[55:52]
  output logic [pec_pkg::M_DATA_W-1:0]    m_tdata,
  // Configuration write port.
  input  logic                            cfg_wr_en,
  input  logic [pec_pkg::CFG_ADDR_W-1:0]  cfg_addr,
  input  logic [pec_pkg::DIM_W-1:0]       cfg_wdata
);
  import pec_pkg::*;

  localparam int LAST = NUM_STAGES - 1;
  localparam logic [DIM_CMP_W-1:0] DimLimit = DIM_CMP_W'(MAX_DIMENSION);

  // Configuration registers.
  logic             output_format;
  logic             flip_vertical;
  logic             premultiply_out;
  logic             source_premultiplied;
  logic [DIM_W-1:0] image_width;
  logic [DIM_W-1:0] image_height;

  // Pipeline registers.
  logic [NUM_STAGES-1:0] vld;
  logic [NUM_STAGES-1:0] rdy;
  pipe_t                 stg      [NUM_STAGES];
  pipe_t                 stg_next [NUM_STAGES];

  // Effective image size.
  logic [DIM_W-1:0] w_eff;
  logic [DIM_W-1:0] h_eff;

  // Register writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      output_format        <= 1'b1;
      flip_vertical        <= 1'b0;
      premultiply_out      <= 1'b0;
      source_premultiplied <= 1'b0;
      image_width          <= DIM_W'(1);
      image_height         <= DIM_W'(1);
    end else if (cfg_wr_en) begin
      unique case (cfg_addr)
        REG_OUTPUT_FORMAT:        output_format        <= cfg_wdata[0];
        REG_FLIP_VERTICAL:        flip_vertical        <= cfg_wdata[0];
        REG_PREMULTIPLY_OUT:      premultiply_out      <= cfg_wdata[0];
        REG_SOURCE_PREMULTIPLIED: source_premultiplied <= cfg_wdata[0];
        REG_IMAGE_WIDTH:          image_width          <= cfg_wdata;
        REG_IMAGE_HEIGHT:         image_height         <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Zero is treated as one and anything above the limit is saturated.
  always_comb begin
    if (image_width == '0) begin
      w_eff = DIM_W'(1);
    end else if ({2'b0, image_width} > DimLimit) begin
      w_eff = DIM_W'(DimLimit);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = DIM_W'(1);
    end else if ({2'b0, image_height} > DimLimit) begin
      h_eff = DIM_W'(DimLimit);
    end else begin
      h_eff = image_height;
    end
  end

  // A stage can take a word when it is empty or its own word moves on.
  always_comb begin
    rdy[LAST] = ~vld[LAST] | m_tready;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = ~vld[k] | rdy[k + 1];
    end
  end

  assign s_tready = rdy[0];

  // Datapath of every stage.
  always_comb begin
    logic [DIM_W-1:0] col_c;
    logic [DIM_W-1:0] row_c;
    logic [8:0]       step;
    logic [12:0]      qnum;
    logic             convert;

    // Stage 0: capture the incoming word.
    stg_next[0]       = stg[0];
    stg_next[0].col   = s_tdata[11:0];
    stg_next[0].row   = s_tdata[23:12];
    stg_next[0].chan  = {s_tdata[47:40], s_tdata[39:32], s_tdata[31:24]};
    stg_next[0].alpha = s_tdata[55:48];

    // Stage 1: clamp coordinates, flip, pitch and the per-channel numerators.
    stg_next[1] = stg[0];
    col_c = ({1'b0, stg[0].col} >= w_eff) ? w_eff - DIM_W'(1) : {1'b0, stg[0].col};
    row_c = ({1'b0, stg[0].row} >= h_eff) ? h_eff - DIM_W'(1) : {1'b0, stg[0].row};
    stg_next[1].ty = flip_vertical ? (h_eff - DIM_W'(1) - row_c) : row_c;
    convert = output_format & (source_premultiplied != premultiply_out);
    stg_next[1].fmt_rgba    = output_format;
    stg_next[1].do_premul   = convert & premultiply_out;
    stg_next[1].do_unpremul = convert & ~premultiply_out;
    if (output_format) begin
      stg_next[1].pitch = {1'b0, w_eff, 1'b0};
      stg_next[1].colb  = {col_c, 1'b0};
    end else begin
      stg_next[1].pitch = {2'b0, w_eff} + {1'b0, w_eff, 1'b0};
      stg_next[1].colb  = 14'({1'b0, col_c} + {col_c, 1'b0});
    end
    for (int ch = 0; ch < 3; ch++) begin
      if (premultiply_out) begin
        stg_next[1].num[ch] = 16'({8'b0, stg[0].chan[ch]} * {8'b0, stg[0].alpha}) + 16'd127;
      end else begin
        stg_next[1].num[ch] = ({stg[0].chan[ch], 8'b0} - {8'b0, stg[0].chan[ch]})
                            + {9'b0, stg[0].alpha[7:1]};
      end
    end

    // Stage 2: row offset product, divide-by-255 product, first divider steps.
    stg_next[2] = stg[1];
    stg_next[2].off_prod = 28'({15'b0, stg[1].ty} * {13'b0, stg[1].pitch});
    for (int ch = 0; ch < 3; ch++) begin
      stg_next[2].pm_prod[ch] = {16'b0, stg[1].num[ch]} * {16'b0, RECIP_255};
      stg_next[2].ovf[ch]     = stg[1].num[ch][15:8] >= stg[1].alpha;
      stg_next[2].rem[ch]     = stg[1].num[ch][15:8];
      stg_next[2].quo[ch]     = '0;
      for (int s = 0; s < 3; s++) begin
        step = div_step(stg_next[2].rem[ch], stg[1].num[ch][7 - s], stg[1].alpha);
        stg_next[2].rem[ch] = step[7:0];
        stg_next[2].quo[ch] = {stg_next[2].quo[ch][6:0], step[8]};
      end
    end

    // Stage 3: final offset, premultiplied channel, middle divider steps.
    stg_next[3] = stg[2];
    stg_next[3].offset = OFFSET_W'(stg[2].off_prod + {14'b0, stg[2].colb});
    for (int ch = 0; ch < 3; ch++) begin
      stg_next[3].pm_q[ch] = stg[2].pm_prod[ch][RECIP_SHIFT +: CHAN_W];
      for (int s = 3; s < 6; s++) begin
        step = div_step(stg_next[3].rem[ch], stg[2].num[ch][7 - s], stg[2].alpha);
        stg_next[3].rem[ch] = step[7:0];
        stg_next[3].quo[ch] = {stg_next[3].quo[ch][6:0], step[8]};
      end
    end

    // Stage 4: last divider steps and the channel value after alpha handling.
    stg_next[4] = stg[3];
    for (int ch = 0; ch < 3; ch++) begin
      for (int s = 6; s < 8; s++) begin
        step = div_step(stg_next[4].rem[ch], stg[3].num[ch][7 - s], stg[3].alpha);
        stg_next[4].rem[ch] = step[7:0];
        stg_next[4].quo[ch] = {stg_next[4].quo[ch][6:0], step[8]};
      end
      if (stg[3].do_premul) begin
        stg_next[4].val[ch] = stg[3].pm_q[ch];
      end else if (stg[3].do_unpremul) begin
        if (stg[3].alpha == '0) begin
          stg_next[4].val[ch] = '0;
        end else if (stg[3].ovf[ch]) begin
          stg_next[4].val[ch] = '1;
        end else begin
          stg_next[4].val[ch] = stg_next[4].quo[ch];
        end
      end else begin
        stg_next[4].val[ch] = stg[3].chan[ch];
      end
    end

    // Stage 5: quantizer product, (v * 31 + 127) times the reciprocal of 255.
    stg_next[5] = stg[4];
    for (int ch = 0; ch < 3; ch++) begin
      qnum = 13'({stg[4].val[ch], 5'b0} - {5'b0, stg[4].val[ch]}) + 13'd127;
      stg_next[5].q_prod[ch] = {16'b0, qnum} * {13'b0, RECIP_255};
    end

    // Stage 6: pack the pixel bytes.
    stg_next[6] = stg[5];
    if (stg[5].fmt_rgba) begin
      stg_next[6].bpp   = BPP_RGBA5551;
      stg_next[6].pixel = {8'b0,
                           stg[5].q_prod[0][RECIP_SHIFT +: 5],
                           stg[5].q_prod[1][RECIP_SHIFT +: 5],
                           stg[5].q_prod[2][RECIP_SHIFT +: 5],
                           stg[5].alpha[7]};
    end else begin
      stg_next[6].bpp   = BPP_RGB888;
      stg_next[6].pixel = {stg[5].chan[2], stg[5].chan[1], stg[5].chan[0]};
    end
  end

  // Valid bits travel with the data.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      for (int k = 0; k < NUM_STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= (k == 0) ? s_tvalid : vld[(k == 0) ? 0 : k - 1];
        end
      end
    end
  end

  // Stage payloads.
  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_STAGES; k++) begin
      if (rdy[k]) begin
        stg[k] <= stg_next[k];
      end
    end
  end

  // Output word.
  assign m_tvalid = vld[LAST];
  assign m_tdata  = {4'b0, stg[LAST].bpp, stg[LAST].pixel, stg[LAST].offset};

  `include "pixel_export_converter_macros.svh"

  `PEC_ASSERT_SAME(a_stall_only_when_full, !s_tready, &vld, "input stalled with a free stage")
  `PEC_ASSERT_SAME(a_count_legal, m_tvalid, (stg[LAST].bpp == BPP_RGB888) || (stg[LAST].bpp == BPP_RGBA5551), "bad byte count")
  `PEC_ASSERT_SAME(a_word_top_zero, m_tvalid && (stg[LAST].bpp == BPP_RGBA5551), stg[LAST].pixel[23:16] == 8'd0, "RGBA5551 word has a third byte")
  `PEC_ASSERT_NEXT(a_bubble_enters, s_tready && !s_tvalid, !vld[0], "first stage filled without an input word")

endmodule

`default_nettype wire
